FILE: rtl/cme_pkg.sv
// Shared types and constants for the clamp / running median / EMA / alert block.
// Used by cme_cell and clamp_median_ema_hysteresis_alert; no dependencies.
`default_nettype none

package cme_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int WEIGHT_W   = 9;
    localparam int AGE_W      = 4;   // covers window sizes up to 16
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [AGE_W-1:0]           t_age;
    typedef logic [WEIGHT_W-1:0]        t_weight;
    typedef logic [CFG_IDX_W-1:0]       t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0]      t_cfg_data;

    localparam t_cfg_idx CFG_CLAMP_LOW  = 3'd0;
    localparam t_cfg_idx CFG_CLAMP_HIGH = 3'd1;
    localparam t_cfg_idx CFG_ALERT_ON   = 3'd2;
    localparam t_cfg_idx CFG_ALERT_OFF  = 3'd3;
    localparam t_cfg_idx CFG_WEIGHT     = 3'd4;

    localparam t_sample RST_CLAMP_LOW  = -16'sd10240;
    localparam t_sample RST_CLAMP_HIGH = 16'sd32000;
    localparam t_sample RST_ALERT_ON   = 16'sd7680;
    localparam t_sample RST_ALERT_OFF  = 16'sd7168;
    localparam t_weight RST_WEIGHT     = 9'd51;
    localparam t_weight WEIGHT_FULL    = 9'd256;

    // What a cell shows its neighbors.
    typedef struct packed {
        t_sample val;   // held window value
        t_age    age;   // requests since this value entered
        logic    gt;    // unused, or value above the new sample
        logic    del;   // this cell or one to its left is evicted
    } t_cell_link;

    // Broadcast control from the sequencer to every cell.
    typedef struct packed {
        logic    do_del;    // close the gap of the evicted entry
        logic    do_ins;    // open a slot and insert the sample
        logic    evict;     // window full: the oldest entry leaves
        t_age    last_age;  // age of the oldest entry in a full window
        t_sample sample;    // clamped sample being inserted
    } t_cell_ctl;

endpackage

`default_nettype wire

FILE: rtl/cme_cell.sv
// One cell of the sorted window chain: holds a value and its age and trades
// them with its neighbors. Depends on cme_pkg.
`default_nettype none

module cme_cell (
    input  wire                     i_clk,
    input  cme_pkg::t_cell_ctl      i_ctl,
    input  wire                     i_used,
    input  cme_pkg::t_cell_link     i_left,
    input  cme_pkg::t_cell_link     i_right,
    output cme_pkg::t_cell_link     o_link
);
    import cme_pkg::*;

    t_sample r_val;
    t_age    r_age;
    t_sample n_val;
    t_age    n_age;
    logic    w_gt;
    logic    w_del;

    assign w_gt  = !i_used || ($signed(r_val) > $signed(i_ctl.sample));
    assign w_del = i_left.del || (i_ctl.evict && (r_age == i_ctl.last_age));

    assign o_link.val = r_val;
    assign o_link.age = r_age;
    assign o_link.gt  = w_gt;
    assign o_link.del = w_del;

    always_comb begin
        n_val = r_val;
        n_age = r_age;
        if (i_ctl.do_del) begin
            // shift left over the evicted entry
            if (w_del) begin
                n_val = i_right.val;
                n_age = i_right.age;
            end
        end else if (i_ctl.do_ins) begin
            if (i_left.gt) begin
                n_val = i_left.val;
                n_age = i_left.age + t_age'(1);
            end else if (w_gt) begin
                n_val = i_ctl.sample;
                n_age = '0;
            end else begin
                n_age = r_age + t_age'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_age <= n_age;
    end

endmodule

`default_nettype wire

FILE: rtl/clamp_median_ema_hysteresis_alert.sv
// Top level: clamp, sorted-window running median (chain of cme_cell),
// EMA smoothing and hysteresis alert. Depends on cme_pkg and cme_cell.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-----------------------------------
//   input    | i_in_valid / o_in_stall    | i_raw_sample
//   output   | o_out_valid / i_out_stall  | o_median_value, o_smoothed_value,
//            |                            | o_alert_active
//   config   | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// A request passes through these steps in order: accept and clamp, evict the
// oldest entry, sorted insert across the cell chain, median pick, weight
// multiply, average update. One request is in flight at a time.
// The finished result sits in the output register, so the next request is
// taken while it waits; a held result stalls only the final average step.
// Reset (synchronous, active low) empties the window and clears the average
// and alert.
`default_nettype none

module clamp_median_ema_hysteresis_alert #(
    parameter int WINDOW_SIZE = 5
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_stall,
    input  cme_pkg::t_sample        i_raw_sample,
    output logic                    o_out_valid,
    input  wire                     i_out_stall,
    output cme_pkg::t_sample        o_median_value,
    output cme_pkg::t_sample        o_smoothed_value,
    output logic                    o_alert_active,
    input  wire                     i_cfg_we,
    input  cme_pkg::t_cfg_idx       i_cfg_index,
    input  cme_pkg::t_cfg_data      i_cfg_data
);
    import cme_pkg::*;

    localparam int CNT_W = $clog2(WINDOW_SIZE + 1);
    localparam int IDX_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int PROD_W = SAMPLE_W + WEIGHT_W + 2;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW_SIZE);
    localparam t_age LAST_AGE = AGE_W'(WINDOW_SIZE - 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DEL  = 6'b000010,
        S_INS  = 6'b000100,
        S_MED  = 6'b001000,
        S_MUL  = 6'b010000,
        S_AVG  = 6'b100000
    } t_state;

    t_state              r_state;
    t_state              n_state;
    t_sample             r_clamp_low;
    t_sample             r_clamp_high;
    t_sample             r_alert_on;
    t_sample             r_alert_off;
    t_weight             r_weight;
    logic [CNT_W-1:0]    r_count;
    t_sample             r_x;
    t_sample             r_med;
    logic signed [PROD_W-1:0] r_prod;
    t_sample             r_avg;
    logic                r_started;
    logic                r_alert;
    logic                r_out_valid;
    t_sample             r_out_med;
    t_sample             r_out_avg;
    logic                r_out_alert;

    logic                w_in_acc;
    logic                w_out_free;
    t_sample             w_clamped;
    logic [CNT_W-1:0]    w_live;
    logic [CNT_W-1:0]    w_mid;
    t_weight             w_weight_sat;
    logic signed [WEIGHT_W:0]   w_weight_s;
    logic signed [SAMPLE_W:0]   w_diff;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [SAMPLE_W+2:0] w_sum;
    t_sample             w_avg_next;
    t_cell_ctl           w_ctl;
    t_cell_link          w_link  [WINDOW_SIZE];
    t_cell_link          w_left  [WINDOW_SIZE];
    t_cell_link          w_right [WINDOW_SIZE];
    logic                w_used  [WINDOW_SIZE];

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Low limit wins when both limits apply, as they can when the limits are crossed.
    always_comb begin
        if ($signed(i_raw_sample) < $signed(r_clamp_low)) begin
            w_clamped = r_clamp_low;
        end else if ($signed(i_raw_sample) > $signed(r_clamp_high)) begin
            w_clamped = r_clamp_high;
        end else begin
            w_clamped = i_raw_sample;
        end
    end

    // Entries live during insert: a full window has just lost its oldest one.
    assign w_live = (r_count == CNT_FULL) ? CNT_W'(WINDOW_SIZE - 1) : r_count;

    assign w_ctl.do_del   = (r_state == S_DEL);
    assign w_ctl.do_ins   = (r_state == S_INS);
    assign w_ctl.evict    = (r_count == CNT_FULL);
    assign w_ctl.last_age = LAST_AGE;
    assign w_ctl.sample   = r_x;

    for (genvar g = 0; g < WINDOW_SIZE; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_left[g] = '0;
        end else begin : g_mid
            assign w_left[g] = w_link[g-1];
        end
        if (g == WINDOW_SIZE - 1) begin : g_last
            assign w_right[g] = '0;
        end else begin : g_inner
            assign w_right[g] = w_link[g+1];
        end
        assign w_used[g] = (CNT_W'(g) < w_live);

        cme_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_used  (w_used[g]),
            .i_left  (w_left[g]),
            .i_right (w_right[g]),
            .o_link  (w_link[g])
        );
    end

    assign w_mid = r_count >> 1;

    // avg + floor(w * (med - avg) / 256) equals the weighted floor average.
    assign w_weight_sat = r_weight[WEIGHT_W-1] ? WEIGHT_FULL : r_weight;
    assign w_weight_s   = $signed({1'b0, w_weight_sat});
    assign w_diff       = $signed({r_med[SAMPLE_W-1], r_med})
                        - $signed({r_avg[SAMPLE_W-1], r_avg});
    assign w_prod       = w_weight_s * w_diff;
    assign w_sum        = $signed({{3{r_avg[SAMPLE_W-1]}}, r_avg})
                        + $signed(r_prod[PROD_W-1:8]);
    assign w_avg_next   = r_started ? w_sum[SAMPLE_W-1:0] : r_med;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_DEL;
                end
            end
            S_DEL:  n_state = S_INS;
            S_INS:  n_state = S_MED;
            S_MED:  n_state = S_MUL;
            S_MUL:  n_state = S_AVG;
            S_AVG: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_clamp_low  <= RST_CLAMP_LOW;
            r_clamp_high <= RST_CLAMP_HIGH;
            r_alert_on   <= RST_ALERT_ON;
            r_alert_off  <= RST_ALERT_OFF;
            r_weight     <= RST_WEIGHT;
            r_count      <= '0;
            r_avg        <= '0;
            r_started    <= 1'b0;
            r_alert      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CLAMP_LOW:  r_clamp_low  <= i_cfg_data;
                    CFG_CLAMP_HIGH: r_clamp_high <= i_cfg_data;
                    CFG_ALERT_ON:   r_alert_on   <= i_cfg_data;
                    CFG_ALERT_OFF:  r_alert_off  <= i_cfg_data;
                    CFG_WEIGHT:     r_weight     <= i_cfg_data[WEIGHT_W-1:0];
                    default: ;
                endcase
            end
            if ((r_state == S_INS) && (r_count != CNT_FULL)) begin
                r_count <= r_count + CNT_W'(1);
            end
            // High test first
            if (r_state == S_MUL) begin
                if ($signed(r_med) >= $signed(r_alert_on)) begin
                    r_alert <= 1'b1;
                end else if ($signed(r_med) <= $signed(r_alert_off)) begin
                    r_alert <= 1'b0;
                end
            end
            if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if ((r_state == S_AVG) && w_out_free) begin
                r_avg       <= w_avg_next;
                r_started   <= 1'b1;
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_x <= w_clamped;
        end
        if (r_state == S_MED) begin
            r_med <= w_link[w_mid[IDX_W-1:0]].val;
        end
        if (r_state == S_MUL) begin
            r_prod <= w_prod;
        end
        if ((r_state == S_AVG) && w_out_free) begin
            r_out_med   <= r_med;
            r_out_avg   <= w_avg_next;
            r_out_alert <= r_alert;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_median_value   = r_out_med;
    assign o_smoothed_value = r_out_avg;
    assign o_alert_active   = r_out_alert;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("window fill count above window size");

    a_out_from_avg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_AVG))
        else $error("result presented outside the average step");

    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_DEL))
        else $error("accepted request did not enter eviction");

    a_alert_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_AVG) && ($signed(r_med) >= $signed(r_alert_on))) |-> r_alert)
        else $error("alert not set for median at or above the on level");

endmodule

`default_nettype wire

FILE: bench/clamp_median_ema_hysteresis_alert_tb.sv
// Self-checking bench for clamp_median_ema_hysteresis_alert: sends samples,
// predicts median, running average and alert for each request, and checks results.
// Depends on cme_pkg and the clamp_median_ema_hysteresis_alert RTL.

module clamp_median_ema_hysteresis_alert_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cme_pkg::*;

    localparam int WIN         = 5;
    localparam int DRAIN_LIMIT = 20000;
    localparam int SETTLE      = 10;

    typedef struct {
        t_sample median;
        t_sample smoothed;
        logic    alert;
    } t_filter_out;

    logic      i_clk        = 1'b0;
    logic      i_rst_n      = 1'b0;
    logic      i_in_valid   = 1'b0;
    logic      o_in_stall;
    t_sample   i_raw_sample = '0;
    logic      o_out_valid;
    logic      i_out_stall  = 1'b0;
    t_sample   o_median_value;
    t_sample   o_smoothed_value;
    logic      o_alert_active;
    logic      i_cfg_we     = 1'b0;
    t_cfg_idx  i_cfg_index  = CFG_CLAMP_LOW;
    t_cfg_data i_cfg_data   = '0;

    clamp_median_ema_hysteresis_alert #(.WINDOW_SIZE(WIN)) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_raw_sample     (i_raw_sample),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_median_value   (o_median_value),
        .o_smoothed_value (o_smoothed_value),
        .o_alert_active   (o_alert_active),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Filter model: configuration and state
    int lim_low, lim_high, on_level, off_level, weight;
    int window_vals[WIN];
    int wr_slot, fill_cnt, avg_val;
    bit avg_loaded, alert_state;

    t_filter_out expected_q[$];
    int error_count = 0;

    int idle_pct = 0;
    int stall_pct = 0;
    int hold_req_len = 0;
    int hold_req_id = 0;
    int hold_id_seen = 0;
    int hold_left = 0;
    int walk_val = 0;

    function automatic void reset_filter_model();
        lim_low     = RST_CLAMP_LOW;
        lim_high    = RST_CLAMP_HIGH;
        on_level    = RST_ALERT_ON;
        off_level   = RST_ALERT_OFF;
        weight      = RST_WEIGHT;
        wr_slot     = 0;
        fill_cnt    = 0;
        avg_val     = 0;
        avg_loaded  = 1'b0;
        alert_state = 1'b0;
        foreach (window_vals[k]) window_vals[k] = 0;
    endfunction

    function automatic void set_register(t_cfg_idx idx, t_cfg_data data);
        case (idx)
            CFG_CLAMP_LOW:  lim_low   = $signed(data);
            CFG_CLAMP_HIGH: lim_high  = $signed(data);
            CFG_ALERT_ON:   on_level  = $signed(data);
            CFG_ALERT_OFF:  off_level = $signed(data);
            CFG_WEIGHT:     weight    = data[WEIGHT_W-1:0];
            default: ;
        endcase
    endfunction

    // Clamp, push into the ring, take the upper-middle median, update average and alert.
    function automatic t_filter_out filter_step(t_sample raw);
        int x, key, j, med, w;
        int sorted[WIN];
        t_filter_out r;
        x = raw;
        if (x < lim_low) x = lim_low;
        else if (x > lim_high) x = lim_high;
        window_vals[wr_slot] = x;
        wr_slot = (wr_slot + 1) % WIN;
        if (fill_cnt < WIN) fill_cnt++;
        for (int i = 0; i < fill_cnt; i++) sorted[i] = window_vals[i];
        for (int i = 1; i < fill_cnt; i++) begin
            key = sorted[i];
            j = i;
            while (j > 0 && sorted[j-1] > key) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = key;
        end
        med = sorted[fill_cnt / 2];
        w = (weight > 256) ? 256 : weight;
        if (!avg_loaded) begin
            avg_val = med;
            avg_loaded = 1'b1;
        end else begin
            avg_val = (w * med + (256 - w) * avg_val) >>> 8;
        end
        if (med >= on_level) alert_state = 1'b1;
        else if (med <= off_level) alert_state = 1'b0;
        r.median   = med[15:0];
        r.smoothed = avg_val[15:0];
        r.alert    = alert_state;
        return r;
    endfunction

    // Result checker
    always @(posedge i_clk) begin : result_check
        t_filter_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result median=%0d smoothed=%0d alert=%0b",
                         $time, o_median_value, o_smoothed_value, o_alert_active);
                error_count++;
            end else begin
                want = expected_q.pop_front();
                if (o_median_value !== want.median) begin
                    $display("%0t: median_value expected %0d got %0d",
                             $time, want.median, o_median_value);
                    error_count++;
                end
                if (o_smoothed_value !== want.smoothed) begin
                    $display("%0t: smoothed_value expected %0d got %0d",
                             $time, want.smoothed, o_smoothed_value);
                    error_count++;
                end
                if (o_alert_active !== want.alert) begin
                    $display("%0t: alert_active expected %0b got %0b",
                             $time, want.alert, o_alert_active);
                    error_count++;
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold when one is requested
    always @(negedge i_clk) begin
        if (hold_req_id != hold_id_seen) begin
            hold_id_seen = hold_req_id;
            hold_left = hold_req_len;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Entered and left at a falling edge; drop valid right after the accept so
    // no stale request is offered.
    task automatic send_sample(input t_sample s);
        while ($urandom_range(0, 99) < idle_pct) begin
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_raw_sample <= s;
        do @(posedge i_clk); while (o_in_stall);
        expected_q.push_back(filter_step(s));
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        int cycles;
        cycles = 0;
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0 && cycles < DRAIN_LIMIT) begin
            @(negedge i_clk);
            cycles++;
        end
        if (expected_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_q.size());
            error_count++;
            expected_q.delete();
        end
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[15:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        set_register(idx, value[15:0]);
        @(negedge i_clk);
    endtask

    function automatic int rand_level();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic t_sample pick_sample();
        int v;
        case ($urandom_range(0, 4))
            0: v = $urandom_range(0, 65535);
            1: v = on_level + int'($urandom_range(0, 64)) - 32;
            2: v = off_level + int'($urandom_range(0, 64)) - 32;
            3: v = ($urandom_range(0, 1) ? lim_low : lim_high) + int'($urandom_range(0, 8)) - 4;
            default: begin
                // drift slowly so the median walks across both alert levels
                walk_val += int'($urandom_range(0, 512)) - 256;
                if (walk_val < -32768 || walk_val > 32767) walk_val = on_level;
                v = walk_val;
            end
        endcase
        return v[15:0];
    endfunction

    task automatic randomize_config();
        int lo, hi, on_lv, off_lv, t;
        wait_idle();
        lo = rand_level();
        hi = rand_level();
        // mostly ordered limits, sometimes crossed
        if ($urandom_range(0, 4) != 0 && lo > hi) begin
            t = lo; lo = hi; hi = t;
        end
        case ($urandom_range(0, 5))
            0: lo = -32768;
            1: hi = 32767;
            2: begin lo = -32768; hi = 32767; end
            default: ;
        endcase
        on_lv = rand_level();
        off_lv = rand_level();
        if ($urandom_range(0, 3) != 0 && on_lv < off_lv) begin
            t = on_lv; on_lv = off_lv; off_lv = t;
        end
        case ($urandom_range(0, 7))
            0: on_lv = -32768;
            1: on_lv = 32767;
            2: off_lv = -32768;
            3: off_lv = 32767;
            default: ;
        endcase
        write_reg(CFG_CLAMP_LOW, lo);
        write_reg(CFG_CLAMP_HIGH, hi);
        write_reg(CFG_ALERT_ON, on_lv);
        write_reg(CFG_ALERT_OFF, off_lv);
        case ($urandom_range(0, 5))
            0: write_reg(CFG_WEIGHT, 0);
            1: write_reg(CFG_WEIGHT, 256);
            2: write_reg(CFG_WEIGHT, 511);
            default: write_reg(CFG_WEIGHT, $urandom_range(0, 511));
        endcase
        walk_val = on_lv;
    endtask

    // Reset settings: fill the window from one to five entries, then wrap.
    task automatic test_window_fill();
        send_sample(16'sh8000);
        send_sample(16'sh7fff);
        send_sample(16'sd256);
        send_sample(16'sd7680);
        send_sample(-16'sd256);
        send_sample(16'sd0);
    endtask

    task automatic test_clamp_limits();
        wait_idle();
        write_reg(CFG_CLAMP_LOW, -32768);
        write_reg(CFG_CLAMP_HIGH, 32767);
        send_sample(16'sh8000);
        send_sample(16'sh7fff);
        // crossed limits: below low yields low, anything else above high yields high
        wait_idle();
        write_reg(CFG_CLAMP_LOW, 1000);
        write_reg(CFG_CLAMP_HIGH, -1000);
        send_sample(-16'sd5000);
        send_sample(16'sd5000);
        send_sample(16'sd0);
    endtask

    task automatic test_weight_ends();
        wait_idle();
        write_reg(CFG_CLAMP_LOW, -32768);
        write_reg(CFG_CLAMP_HIGH, 32767);
        write_reg(CFG_WEIGHT, 0);
        send_sample(16'sd1000);
        wait_idle();
        write_reg(CFG_WEIGHT, 256);
        send_sample(-16'sd3000);
        wait_idle();
        write_reg(CFG_WEIGHT, 511);
        send_sample(16'sd2000);
        wait_idle();
        write_reg(CFG_WEIGHT, 300);
        send_sample(16'sd500);
        wait_idle();
        write_reg(CFG_WEIGHT, 1);
        send_sample(16'sh7fff);
    endtask

    task automatic test_alert_levels();
        // overlapping levels: the set test wins
        wait_idle();
        write_reg(CFG_ALERT_ON, 0);
        write_reg(CFG_ALERT_OFF, 100);
        send_sample(16'sd50);
        send_sample(16'sd50);
        // wide gap: a median between the levels holds the flag
        wait_idle();
        write_reg(CFG_ALERT_ON, 1000);
        write_reg(CFG_ALERT_OFF, -1000);
        send_sample(16'sd0);
        send_sample(16'sd0);
        wait_idle();
        write_reg(CFG_ALERT_ON, -32768);
        write_reg(CFG_ALERT_OFF, 32767);
        send_sample(16'sd0);
        wait_idle();
        write_reg(CFG_ALERT_ON, 32767);
        write_reg(CFG_ALERT_OFF, -32768);
        send_sample(16'sd0);
    endtask

    task automatic test_random_phases();
        int idle_set[4]  = '{0, 47, 0, 11};
        int stall_set[4] = '{0, 0, 47, 11};
        for (int p = 0; p < 4; p++) begin
            for (int c = 0; c < 2; c++) begin
                randomize_config();
                idle_pct  = idle_set[p];
                stall_pct = stall_set[p];
                repeat (200) send_sample(pick_sample());
            end
        end
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    // Hold the output long enough that the block backs up into its input.
    task automatic test_full_backpressure();
        wait_idle();
        idle_pct  = 0;
        stall_pct = 0;
        hold_req_len = 300;
        hold_req_id++;
        repeat (40) send_sample(pick_sample());
        wait_idle();
    endtask

    initial begin
        reset_filter_model();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_window_fill();
        test_clamp_limits();
        test_weight_ends();
        test_alert_levels();
        test_random_phases();
        test_full_backpressure();
        wait_idle();
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("%0t: timeout", $time);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: sim.f
rtl/cme_pkg.sv
rtl/cme_cell.sv
rtl/clamp_median_ema_hysteresis_alert.sv
bench/clamp_median_ema_hysteresis_alert_tb.sv
